FILE: rtl/core/buddy_page_allocator_assert.svh
// Assertion macros for the buddy page allocator.
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The condition must hold in the cycle after the trigger.
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/bpa_pkg.sv
// Shared types, codes and helpers of the buddy page allocator.
package bpa_pkg;

  localparam int unsigned PAGE_INDEX_BITS_DEF = 12;
  localparam int unsigned MAX_ORDER_DEF       = 10;
  localparam int unsigned REFCOUNT_BITS_DEF   = 16;

  typedef enum logic [1:0] {
    KIND_BODY  = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_ALLOC = 2'd2
  } page_kind_t;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_ADDREF = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_LARGE = 2'd1,
    STAT_NO_MEMORY = 2'd2,
    STAT_NOT_HEAD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] page_count;
    logic [11:0] page_index;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [11:0] block_page;
    logic [3:0]  block_order;
  } result_t;

  // Smallest order whose block holds the requested pages; zero pages count as one.
  function automatic logic [4:0] count_order(input logic [15:0] count);
    logic [15:0] v;
    logic [4:0]  o;
    v = count - 16'd1;
    o = 5'd0;
    if (count > 16'd1) begin
      for (int i = 0; i < 16; i++) begin
        if (v[i]) begin
          o = 5'(i + 1);
        end
      end
    end
    return o;
  endfunction

endpackage

FILE: rtl/core/bpa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module bpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/buddy_page_allocator.sv
// Buddy page allocator top level: request sequencer over the page metadata and link memories.
// Too-large and unknown requests answer in the cycle after acceptance; add reference and drops
// that leave a count answer once the metadata is read. An allocate searches the orders upward,
// unlinks the block and splits it down; a last free merges with free buddies and relinks.
// One request at a time, the next taken as the result pulses. Reset: a clearing pass over
// every page builds the top-order list under busy; done pulses, no stall.
`include "buddy_page_allocator_assert.svh"

module buddy_page_allocator import bpa_pkg::*; #(
  parameter int unsigned PAGE_INDEX_BITS = PAGE_INDEX_BITS_DEF,
  parameter int unsigned MAX_ORDER       = MAX_ORDER_DEF,
  parameter int unsigned REFCOUNT_BITS   = REFCOUNT_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  localparam int unsigned PB  = PAGE_INDEX_BITS;
  localparam int unsigned RB  = REFCOUNT_BITS;
  localparam int unsigned TOP = (MAX_ORDER < PB) ? MAX_ORDER : PB;
  // Order registers must hold one past the top list while searching.
  localparam int unsigned OB  = $clog2(MAX_ORDER + 2);
  localparam int unsigned HB  = (MAX_ORDER < 1) ? 1 : $clog2(MAX_ORDER + 1);
  localparam int unsigned MW  = 2 + OB + RB;
  localparam int unsigned LW  = PB + 1;
  localparam int unsigned NPAGES = 1 << PB;

  localparam logic [PB:0]   BLK_FULL = (PB + 1)'(1) << TOP;
  localparam logic [PB-1:0] BLK      = BLK_FULL[PB-1:0];
  localparam logic [PB-1:0] MASK     = PB'(BLK_FULL - (PB + 1)'(1));
  localparam logic [LW-1:0] EMPTY    = LW'(NPAGES);
  localparam logic [RB-1:0] REF_MAX  = {RB{1'b1}};

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SEARCH, S_RM_RD, S_RM_WR, S_SPLIT, S_PT_CHK, S_PT_WR1,
    S_PT_WR2, S_CHK, S_MG_TEST, S_MG_CHK, S_MG_HI, S_MG_FIN
  } state_t;

  // Where a list removal or a tail push hands control back to.
  typedef enum logic [1:0] {
    RET_SPLIT, RET_MERGE, RET_FREE
  } ret_t;

  state_t        state;
  ret_t          ret;
  logic [PB-1:0] clr_addr;
  logic [OB-1:0] cur;
  logic [OB-1:0] want;
  logic [PB-1:0] p;
  logic [PB-1:0] rp;
  logic [PB-1:0] pp;
  logic [1:0]    act;
  logic [LW-1:0] head [MAX_ORDER + 1];

  // Memory ports.
  logic          meta_we;
  logic [PB-1:0] meta_waddr, meta_raddr;
  logic [MW-1:0] meta_wdata, md;
  logic          next_we;
  logic [PB-1:0] next_waddr, next_wdata, next_raddr, nd;
  logic          prev_we;
  logic [PB-1:0] prev_waddr, prev_wdata, prev_raddr, pd;

  bpa_ram #(.WIDTH(MW), .DEPTH(NPAGES)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(md)
  );

  bpa_ram #(.WIDTH(PB), .DEPTH(NPAGES)) u_next (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(next_raddr), .rdata(nd)
  );

  bpa_ram #(.WIDTH(PB), .DEPTH(NPAGES)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .raddr(prev_raddr), .rdata(pd)
  );

  // Fields of the metadata word that was read.
  logic [1:0]    md_kind;
  logic [OB-1:0] md_order;
  logic [RB-1:0] md_ref;
  logic [RB-1:0] ref_inc, ref_dec;
  assign md_kind  = md[MW-1 -: 2];
  assign md_order = md[RB +: OB];
  assign md_ref   = md[RB-1:0];
  assign ref_inc  = (md_ref != REF_MAX) ? md_ref + RB'(1) : md_ref;
  assign ref_dec  = (md_ref != '0) ? md_ref - RB'(1) : md_ref;

  logic [HB-1:0] cidx;
  logic [LW-1:0] head_cur;
  logic          list_empty;
  logic [PB-1:0] hp;
  assign cidx       = cur[HB-1:0];
  assign head_cur   = head[cidx];
  assign list_empty = head_cur[PB];
  assign hp         = head_cur[PB-1:0];

  logic [PB-1:0] idx_in;
  logic [4:0]    want_in;
  logic [OB-1:0] cur_m1;
  logic [PB-1:0] half;
  logic [PB-1:0] buddy;
  logic          clr_head;
  assign idx_in   = PB'(request.page_index);
  assign want_in  = count_order(request.page_count);
  assign cur_m1   = cur - OB'(1);
  assign half     = p + (PB'(1) << cur_m1);
  assign buddy    = p ^ (PB'(1) << cur);
  assign clr_head = (clr_addr & MASK) == '0;

  assign busy = (state != S_IDLE);

  // Memory access per sequencer step. Reads and writes of one memory may share a cycle.
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = p;
    meta_wdata = '0;
    meta_raddr = '0;
    next_we    = 1'b0;
    next_waddr = pp;
    next_wdata = pp;
    next_raddr = rp;
    prev_we    = 1'b0;
    prev_waddr = pp;
    prev_wdata = pp;
    prev_raddr = rp;
    case (state)
      S_CLEAR: begin
        // Top-order heads form one ascending ring; every other page is body.
        meta_we    = 1'b1;
        meta_waddr = clr_addr;
        meta_wdata = clr_head ? {KIND_FREE, OB'(TOP), RB'(0)} : {KIND_BODY, OB'(0), RB'(0)};
        next_we    = 1'b1;
        next_waddr = clr_addr;
        next_wdata = clr_head ? clr_addr + BLK : '0;
        prev_we    = 1'b1;
        prev_waddr = clr_addr;
        prev_wdata = clr_head ? clr_addr - BLK : '0;
      end
      S_IDLE: begin
        meta_raddr = idx_in;
      end
      S_RM_WR: begin
        // Unlink rp unless it is the only member of its list.
        if (nd != rp) begin
          next_we    = 1'b1;
          next_waddr = pd;
          next_wdata = nd;
          prev_we    = 1'b1;
          prev_waddr = nd;
          prev_wdata = pd;
        end
      end
      S_SPLIT: begin
        meta_we = 1'b1;
        if (cur > want) begin
          meta_waddr = half;
          meta_wdata = {KIND_FREE, cur_m1, RB'(0)};
        end else begin
          meta_waddr = p;
          meta_wdata = {KIND_ALLOC, want, RB'(1)};
        end
      end
      S_PT_CHK: begin
        prev_raddr = hp;
        if (list_empty) begin
          next_we = 1'b1;
          prev_we = 1'b1;
        end
      end
      S_PT_WR1: begin
        // pd is the old tail of the list.
        next_we    = 1'b1;
        next_waddr = pd;
        next_wdata = pp;
        prev_we    = 1'b1;
        prev_waddr = pp;
        prev_wdata = pd;
      end
      S_PT_WR2: begin
        next_we    = 1'b1;
        next_waddr = pp;
        next_wdata = hp;
        prev_we    = 1'b1;
        prev_waddr = hp;
        prev_wdata = pp;
      end
      S_CHK: begin
        if (md_kind == KIND_ALLOC) begin
          if (act == ACT_ADDREF) begin
            meta_we    = 1'b1;
            meta_wdata = {md_kind, md_order, ref_inc};
          end else if (ref_dec != '0) begin
            meta_we    = 1'b1;
            meta_wdata = {md_kind, md_order, ref_dec};
          end
        end
      end
      S_MG_TEST: begin
        meta_raddr = buddy;
      end
      S_MG_HI: begin
        // The upper half of the merged pair becomes body.
        meta_we    = 1'b1;
        meta_waddr = (rp > p) ? rp : p;
        meta_wdata = {KIND_BODY, OB'(0), RB'(0)};
      end
      S_MG_FIN: begin
        meta_we    = 1'b1;
        meta_wdata = {KIND_FREE, cur, RB'(0)};
      end
      default: begin
      end
    endcase
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      ret      <= RET_SPLIT;
      clr_addr <= '0;
      done     <= 1'b0;
      for (int o = 0; o <= int'(MAX_ORDER); o++) begin
        head[o] <= (o == int'(TOP)) ? LW'(0) : EMPTY;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + PB'(1);
          if (clr_addr == {PB{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            act <= request.action;
            p   <= idx_in;
            if (request.action == ACT_ALLOC) begin
              if (32'(want_in) > MAX_ORDER) begin
                done   <= 1'b1;
                result <= '{STAT_TOO_LARGE, 12'd0, 4'd0};
              end else begin
                want  <= OB'(want_in);
                cur   <= OB'(want_in);
                state <= S_SEARCH;
              end
            end else if (request.action == ACT_FREE || request.action == ACT_ADDREF) begin
              state <= S_CHK;
            end else begin
              done   <= 1'b1;
              result <= '{STAT_NOT_HEAD, 12'd0, 4'd0};
            end
          end
        end
        S_SEARCH: begin
          if (32'(cur) > MAX_ORDER) begin
            done   <= 1'b1;
            result <= '{STAT_NO_MEMORY, 12'd0, 4'd0};
            state  <= S_IDLE;
          end else if (list_empty) begin
            cur <= cur + OB'(1);
          end else begin
            p     <= hp;
            rp    <= hp;
            ret   <= RET_SPLIT;
            state <= S_RM_RD;
          end
        end
        S_RM_RD: begin
          state <= S_RM_WR;
        end
        S_RM_WR: begin
          if (nd == rp) begin
            head[cidx] <= EMPTY;
          end else if (hp == rp) begin
            head[cidx] <= {1'b0, nd};
          end
          state <= (ret == RET_MERGE) ? S_MG_HI : S_SPLIT;
        end
        S_SPLIT: begin
          if (cur > want) begin
            cur   <= cur_m1;
            pp    <= half;
            ret   <= RET_SPLIT;
            state <= S_PT_CHK;
          end else begin
            done   <= 1'b1;
            result <= '{STAT_OK, 12'(p), 4'(want)};
            state  <= S_IDLE;
          end
        end
        S_PT_CHK: begin
          if (list_empty) begin
            head[cidx] <= {1'b0, pp};
            if (ret == RET_FREE) begin
              done   <= 1'b1;
              result <= '{STAT_OK, 12'd0, 4'd0};
              state  <= S_IDLE;
            end else begin
              state <= S_SPLIT;
            end
          end else begin
            state <= S_PT_WR1;
          end
        end
        S_PT_WR1: begin
          state <= S_PT_WR2;
        end
        S_PT_WR2: begin
          if (ret == RET_FREE) begin
            done   <= 1'b1;
            result <= '{STAT_OK, 12'd0, 4'd0};
            state  <= S_IDLE;
          end else begin
            state <= S_SPLIT;
          end
        end
        S_CHK: begin
          if (md_kind != KIND_ALLOC) begin
            done   <= 1'b1;
            result <= '{STAT_NOT_HEAD, 12'd0, 4'd0};
            state  <= S_IDLE;
          end else if (act == ACT_ADDREF || ref_dec != '0) begin
            done   <= 1'b1;
            result <= '{STAT_OK, 12'd0, 4'd0};
            state  <= S_IDLE;
          end else begin
            cur   <= md_order;
            state <= S_MG_TEST;
          end
        end
        S_MG_TEST: begin
          if (32'(cur) < MAX_ORDER && 32'(cur) < PB) begin
            rp    <= buddy;
            state <= S_MG_CHK;
          end else begin
            state <= S_MG_FIN;
          end
        end
        S_MG_CHK: begin
          if (md_kind == KIND_FREE && md_order == cur) begin
            ret   <= RET_MERGE;
            state <= S_RM_RD;
          end else begin
            state <= S_MG_FIN;
          end
        end
        S_MG_HI: begin
          p     <= (rp < p) ? rp : p;
          cur   <= cur + OB'(1);
          state <= S_MG_TEST;
        end
        S_MG_FIN: begin
          pp    <= p;
          ret   <= RET_FREE;
          state <= S_PT_CHK;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted request is either answered at once or keeps the block busy.
  `BPA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "request dropped")
  // No result may appear while the memories are still being built.
  `BPA_ASSERT_NOW(a_clear_quiet, state == S_CLEAR, busy && !done, "result during clear")
  // Failed requests report a zero block.
  `BPA_ASSERT_NOW(a_error_zero, done && result.status != STAT_OK,
                  result.block_page == 12'd0 && result.block_order == 4'd0, "error with block")

endmodule

FILE: test/buddy_page_allocator_tb.sv
// Self-checking testbench for the buddy page allocator, with its own allocator model.
`timescale 1ns / 100ps

module buddy_page_allocator_tb;
  import bpa_pkg::*;

  localparam int NPAGES    = 1 << PAGE_INDEX_BITS_DEF;
  localparam int TOP_ORDER = MAX_ORDER_DEF;
  localparam int REF_MAX   = (1 << REFCOUNT_BITS_DEF) - 1;
  localparam logic [12:0] NO_BLOCK = 13'(NPAGES);
  // The one action code that the block does not know.
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;

  buddy_page_allocator dut (
    .clk(clk), .rst(rst), .start(start), .request(request),
    .busy(busy), .done(done), .result(result)
  );

  always #4 clk = ~clk;

  // Shadow copy of the page metadata and the free lists.
  page_kind_t  kind_of[NPAGES];
  logic [3:0]  order_of[NPAGES];
  logic [15:0] refs_of[NPAGES];
  logic [11:0] next_of[NPAGES];
  logic [11:0] prev_of[NPAGES];
  logic [12:0] first_of[TOP_ORDER+1];

  result_t     pending_results[$];
  logic [11:0] live_blocks[$];
  int          mismatches = 0;
  int          idle_pct = 35;

  function automatic void link_tail(logic [11:0] p, int o);
    logic [11:0] h, t;
    if (first_of[o] == NO_BLOCK) begin
      first_of[o] = {1'b0, p};
      next_of[p] = p;
      prev_of[p] = p;
    end else begin
      h = first_of[o][11:0];
      t = prev_of[h];
      next_of[t] = p;
      prev_of[p] = t;
      next_of[p] = h;
      prev_of[h] = p;
    end
  endfunction

  function automatic void unlink(logic [11:0] p, int o);
    logic [11:0] n, b;
    n = next_of[p];
    b = prev_of[p];
    if (n == p) begin
      first_of[o] = NO_BLOCK;
    end else begin
      next_of[b] = n;
      prev_of[n] = b;
      if (first_of[o] == {1'b0, p}) first_of[o] = {1'b0, n};
    end
  endfunction

  // After reset every top-order block is free and they are chained in ascending order.
  function automatic void allocator_reset();
    for (int p = 0; p < NPAGES; p++) begin
      kind_of[p] = KIND_BODY;
      order_of[p] = '0;
      refs_of[p] = '0;
      next_of[p] = '0;
      prev_of[p] = '0;
    end
    for (int o = 0; o <= TOP_ORDER; o++) first_of[o] = NO_BLOCK;
    for (int p = 0; p < NPAGES; p += (1 << TOP_ORDER)) begin
      kind_of[p] = KIND_FREE;
      order_of[p] = 4'(TOP_ORDER);
      link_tail(12'(p), TOP_ORDER);
    end
  endfunction

  // Applies one request to the shadow state and returns the answer it must produce.
  function automatic result_t allocator_apply(request_t r);
    result_t     res;
    int          want, level, cnt, o;
    logic [11:0] p, half, buddy, idx;
    res = '{status: STAT_OK, block_page: '0, block_order: '0};
    idx = r.page_index;
    if (r.action == ACT_ALLOC) begin
      cnt = (r.page_count == 0) ? 1 : int'(r.page_count);
      want = 0;
      while ((1 << want) < cnt) want++;
      if (want > TOP_ORDER) begin
        res.status = STAT_TOO_LARGE;
        return res;
      end
      level = want;
      while (level <= TOP_ORDER && first_of[level] == NO_BLOCK) level++;
      if (level > TOP_ORDER) begin
        res.status = STAT_NO_MEMORY;
        return res;
      end
      p = first_of[level][11:0];
      unlink(p, level);
      // Upper halves go back as free blocks, largest first.
      while (level > want) begin
        level--;
        half = p + 12'(1 << level);
        kind_of[half] = KIND_FREE;
        order_of[half] = 4'(level);
        refs_of[half] = '0;
        link_tail(half, level);
      end
      kind_of[p] = KIND_ALLOC;
      order_of[p] = 4'(want);
      refs_of[p] = 16'd1;
      res.block_page = p;
      res.block_order = 4'(want);
      return res;
    end
    if (!(r.action inside {ACT_FREE, ACT_ADDREF}) || kind_of[idx] != KIND_ALLOC) begin
      res.status = STAT_NOT_HEAD;
      return res;
    end
    if (r.action == ACT_ADDREF) begin
      if (refs_of[idx] < 16'(REF_MAX)) refs_of[idx]++;
      return res;
    end
    if (refs_of[idx] > 0) refs_of[idx]--;
    if (refs_of[idx] != 0) return res;
    // Last reference gone: merge upward with free buddies of equal order.
    p = idx;
    o = order_of[idx];
    while (o < TOP_ORDER) begin
      buddy = p ^ 12'(1 << o);
      if (kind_of[buddy] != KIND_FREE || order_of[buddy] != 4'(o)) break;
      unlink(buddy, o);
      half = (buddy > p) ? buddy : p;
      kind_of[half] = KIND_BODY;
      order_of[half] = '0;
      refs_of[half] = '0;
      p = (buddy < p) ? buddy : p;
      o++;
    end
    kind_of[p] = KIND_FREE;
    order_of[p] = 4'(o);
    refs_of[p] = '0;
    link_tail(p, o);
    return res;
  endfunction

  // Holds the request on the bus until the block takes it, then records the answer.
  task automatic send_request(logic [1:0] act, logic [15:0] count, logic [11:0] page);
    result_t exp_res;
    request_t r;
    r = '{action: act, page_count: count, page_index: page};
    request <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    exp_res = allocator_apply(r);
    pending_results.push_back(exp_res);
    if (act == ACT_ALLOC && exp_res.status == STAT_OK) live_blocks.push_back(exp_res.block_page);
    for (int i = live_blocks.size() - 1; i >= 0; i--)
      if (kind_of[live_blocks[i]] != KIND_ALLOC) live_blocks.delete(i);
  endtask

  // Drops start now and then, so gaps land on every phase.
  task automatic maybe_idle();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Every result must match the oldest outstanding answer, field by field.
  always @(posedge clk) begin
    result_t want_res;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        want_res = pending_results.pop_front();
        if (result.status !== want_res.status || result.block_page !== want_res.block_page ||
            result.block_order !== want_res.block_order) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want_res, result);
        end
      end
    end
  end

  // Directed sizes: zero pages, exact powers, one past a power, and the limits.
  task automatic test_alloc_sizes();
    send_request(ACT_ALLOC, 16'd0, '0);
    send_request(ACT_ALLOC, 16'd1, '0);
    send_request(ACT_ALLOC, 16'd3, 12'hfff);
    send_request(ACT_ALLOC, 16'd1024, '0);
    send_request(ACT_ALLOC, 16'd1025, '0);
    send_request(ACT_ALLOC, 16'hffff, 12'hfff);
    send_request(ACT_ALLOC, 16'h8000, '0);
    wait_drained();
  endtask

  // Free and add reference on a live block, a body page, free heads, and the unknown action.
  task automatic test_bad_requests();
    send_request(ACT_FREE, '0, 12'd1);
    send_request(ACT_ADDREF, '0, 12'd2);
    send_request(ACT_FREE, '0, 12'hc00);
    send_request(ACT_UNKNOWN, 16'hffff, live_blocks[0]);
    send_request(ACT_FREE, '0, 12'hfff);
    wait_drained();
  endtask

  // A block with several references survives frees until the last one.
  task automatic test_refcounts();
    logic [11:0] blk;
    blk = live_blocks[0];
    send_request(ACT_ADDREF, '0, blk);
    send_request(ACT_ADDREF, '0, blk);
    send_request(ACT_FREE, '0, blk);
    send_request(ACT_FREE, '0, blk);
    send_request(ACT_FREE, '0, blk);
    send_request(ACT_FREE, '0, blk);
    wait_drained();
  endtask

  // A deep stack of references drains one free at a time; afterwards add reference is refused.
  task automatic test_ref_stack();
    logic [11:0] blk;
    blk = live_blocks[0];
    repeat (8) send_request(ACT_ADDREF, '0, blk);
    repeat (9) send_request(ACT_FREE, '0, blk);
    send_request(ACT_ADDREF, '0, blk);
    wait_drained();
  endtask

  // Drain memory to an out-of-memory answer, then free everything so it merges back.
  task automatic test_exhaustion();
    repeat (6) send_request(ACT_ALLOC, 16'd1024, '0);
    send_request(ACT_ALLOC, 16'd1, '0);
    while (live_blocks.size() != 0)
      while (live_blocks.size() != 0 && kind_of[live_blocks[0]] == KIND_ALLOC)
        send_request(ACT_FREE, '0, live_blocks[0]);
    wait_drained();
  endtask

  // Mostly well-formed traffic on live blocks, with some noise mixed in.
  task automatic test_random(int n);
    int pick, ord;
    for (int i = 0; i < n; i++) begin
      idle_pct = (i >= 200 && i < 300) ? 0 : 35;
      pick = $urandom_range(99);
      if (pick < 45 || live_blocks.size() == 0) begin
        ord = ($urandom_range(3) == 0) ? $urandom_range(TOP_ORDER) : $urandom_range(4);
        send_request(ACT_ALLOC,
                     (ord == 0) ? 16'($urandom_range(1)) :
                     16'($urandom_range(1 << ord, (1 << (ord - 1)) + 1)), 12'($urandom));
      end else if (pick < 78) begin
        send_request(ACT_FREE, 16'($urandom), live_blocks[$urandom_range(live_blocks.size()-1)]);
      end else if (pick < 88) begin
        send_request(ACT_ADDREF, 16'($urandom),
                     live_blocks[$urandom_range(live_blocks.size()-1)]);
      end else begin
        send_request(2'($urandom), 16'($urandom), 12'($urandom));
      end
      maybe_idle();
    end
    wait_drained();
  endtask

  initial begin
    allocator_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_alloc_sizes();
    test_bad_requests();
    test_refcounts();
    test_ref_stack();
    test_exhaustion();
    test_random(500);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
